@@ hw/rtl/lhpm_pkg.sv @@
// Shared constants, types and helper functions for the latency histogram monitor.
package lhpm_pkg;
	localparam int BUCKETS = 6;
	localparam int BIN_SIZE = 100;
	localparam int BANK_BINS = BUCKETS * BIN_SIZE;
	localparam int NUM_BANKS = 3;
	localparam int MEM_DEPTH = NUM_BANKS * BANK_BINS;
	localparam int BIN_W = $clog2(BANK_BINS);
	localparam int ADDR_W = $clog2(MEM_DEPTH);
	localparam int NUM_MARKS = 8;
	localparam int MARK_W = 14;
	localparam int PADDR_W = 5;

	localparam logic [1:0] CMD_RECORD = 2'd0;
	localparam logic [1:0] CMD_SNAPSHOT = 2'd1;
	localparam logic [1:0] CMD_QUERY = 2'd2;

	localparam logic [1:0] BANK_GLOBAL = 2'd0;
	localparam logic [1:0] BANK_ONE = 2'd1;
	localparam logic [1:0] BANK_TWO = 2'd2;

	localparam logic [MARK_W-1:0] MARK_RESET [NUM_MARKS] = '{
		14'd5000, 14'd6000, 14'd7000, 14'd8000,
		14'd9000, 14'd9500, 14'd9900, 14'd9950};

	typedef logic [31:0] pow_tab_t [10];
	localparam pow_tab_t POW_TEN = '{
		32'd1, 32'd10, 32'd100, 32'd1000, 32'd10000, 32'd100000,
		32'd1000000, 32'd10000000, 32'd100000000, 32'd1000000000};

	// per-bank summary registers
	typedef struct packed {
		logic [31:0] count;
		logic [63:0] sum;
		logic [31:0] min;
		logic [31:0] max;
	} bank_stat_t;

	localparam bank_stat_t STAT_CLEAR = '{count: 32'd0, sum: 64'd0,
		min: 32'hFFFF_FFFF, max: 32'd0};

	function automatic logic [ADDR_W-1:0] mem_addr(input logic [1:0] bank,
		input logic [BIN_W-1:0] bin);
		logic [ADDR_W+1:0] a;
		a = {{ADDR_W{1'b0}}, bank} * (ADDR_W+2)'(BANK_BINS) + (ADDR_W+2)'(bin);
		return a[ADDR_W-1:0];
	endfunction

	function automatic logic [1:0] safe_bank(input logic [1:0] sel);
		return (sel == BANK_ONE || sel == BANK_TWO) ? sel : BANK_ONE;
	endfunction
endpackage

@@ hw/rtl/lhpm_ram.sv @@
// Generic single-port-write, single-port-read synchronous RAM.
module lhpm_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1800
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule

@@ hw/rtl/lhpm_binner.sv @@
// Sample-to-bin scale search, one scale per cycle, with a reciprocal multiply for the bin.
module lhpm_binner (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	input  logic [31:0]               value,
	output logic                      done,
	output logic                      hit,
	output logic [lhpm_pkg::BIN_W-1:0] bin
);
	import lhpm_pkg::*;

	// Rounded quotient r < S iff v < S*p - p/2 with p = 10^b; compare without dividing.
	// At the passing scale x = v + p/2 < S*p fits 24 bits, and r = (x * ceil(2^s/p)) >> s
	// is exact because 2^s >= S*p*p.
	localparam int SC_W = $clog2(BUCKETS + 1);
	localparam int X_W = 24;
	localparam int M_W = 24;

	typedef logic [M_W-1:0] recip_tab_t [BUCKETS];
	typedef logic [5:0] shift_tab_t [BUCKETS];
	localparam recip_tab_t RECIP = '{
		24'd128, 24'd1639, 24'd10486, 24'd134218, 24'd1717987, 24'd10995117};
	localparam shift_tab_t RSHIFT = '{6'd7, 6'd14, 6'd20, 6'd27, 6'd34, 6'd40};

	logic             busy_q;
	logic             div_q;
	logic [SC_W-1:0]  scale_q;
	logic [31:0]      val_q;
	logic [X_W-1:0]   x_q;
	logic [36:0]      lim;
	logic [36:0]      pw;
	logic [47:0]      prod;
	logic [47:0]      quo;

	always_comb begin
		pw = {5'd0, POW_TEN[scale_q]};
		// limit = S*p - p/2 (p=1 gives S - 0 since ties only exist for b>0)
		lim = pw * 37'(BIN_SIZE) - (pw >> 1);
		prod = {24'd0, x_q} * {24'd0, RECIP[scale_q]};
		quo = prod >> RSHIFT[scale_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			div_q <= 1'b0;
			scale_q <= '0;
			val_q <= '0;
			x_q <= '0;
			done <= 1'b0;
			hit <= 1'b0;
			bin <= '0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				div_q <= 1'b0;
				scale_q <= '0;
				val_q <= value;
			end else if (busy_q && !div_q) begin
				if ({5'd0, val_q} < lim) begin
					// hold x = v + p/2 for the reciprocal multiply
					div_q <= 1'b1;
					x_q <= X_W'({5'd0, val_q} + (pw >> 1));
				end else if (scale_q == SC_W'(BUCKETS - 1)) begin
					busy_q <= 1'b0;
					done <= 1'b1;
					hit <= 1'b0;
				end else begin
					scale_q <= scale_q + 1'b1;
				end
			end else if (busy_q) begin
				busy_q <= 1'b0;
				div_q <= 1'b0;
				done <= 1'b1;
				hit <= 1'b1;
				bin <= BIN_W'(scale_q * BIN_SIZE) + BIN_W'(quo);
			end
		end
	end
endmodule

@@ hw/rtl/latency_histogram_percentile_monitor.sv @@
// Top level: command sequencer around the bin-count memory.
// Record: scale search, one scale per cycle, a reciprocal multiply, then two read-modify-writes
// (active bank, then global bank); a dropped sample skips the writes. Snapshot: swaps the
// banks and clears the new active bank's registers and bins. Query: a 600-bin walk, then
// one result word per mark while out_stall is low. Reset restores the marks and clears the
// bank registers at once, then a pass over all 1800 entries zeroes the memory while no item is accepted.
module latency_histogram_percentile_monitor (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_stall,
	input  logic [1:0]                   command,
	input  logic [31:0]                  sample_value,
	input  logic                         query_set,
	output logic                         out_valid,
	input  logic                         out_stall,
	output logic [2:0]                   mark_index,
	output logic [31:0]                  percentile_value,
	output logic [31:0]                  sample_count,
	output logic [63:0]                  sample_sum,
	output logic [31:0]                  smallest_seen,
	output logic [31:0]                  largest_seen,
	output logic                         last_of_run,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [lhpm_pkg::PADDR_W-1:0] paddr,
	input  logic [31:0]                  pwdata,
	output logic [31:0]                  prdata,
	output logic                         pready
);
	import lhpm_pkg::*;

	localparam logic [3:0] ST_CLEAR = 4'd0;
	localparam logic [3:0] ST_IDLE = 4'd1;
	localparam logic [3:0] ST_BIN = 4'd2;
	localparam logic [3:0] ST_RD = 4'd3;
	localparam logic [3:0] ST_WR = 4'd4;
	localparam logic [3:0] ST_SNAP = 4'd5;
	localparam logic [3:0] ST_WALK = 4'd6;
	localparam logic [3:0] ST_OUT = 4'd7;

	logic [3:0]         state_q;
	logic [MARK_W-1:0]  marks_q [NUM_MARKS];
	bank_stat_t         stat_q [NUM_BANKS];
	logic [1:0]         act_q;
	logic [1:0]         snap_q;
	logic [ADDR_W-1:0]  clr_q;
	logic [BIN_W-1:0]   idx_q;
	logic [BIN_W-1:0]   bin_q;
	logic [31:0]        samp_q;
	logic               pass_q;
	logic [1:0]         qbank_q;
	logic [2:0]         mp_q;
	logic               marks_done_q;
	logic [63:0]        total_q;
	logic [31:0]        vals_q [NUM_MARKS];
	logic               rd_pend_q;
	logic [2:0]         oi_q;
	logic [2:0]         wscale_q;
	logic [6:0]         wrem_q;

	logic               bin_start;
	logic               bin_done;
	logic               bin_hit;
	logic [BIN_W-1:0]   bin_idx;

	logic               we;
	logic [ADDR_W-1:0]  waddr;
	logic [31:0]        wdata;
	logic [ADDR_W-1:0]  raddr;
	logic [31:0]        rdata;
	logic [1:0]         rec_bank;
	logic               accept;
	logic               take_mark;
	logic [63:0]        lhs;
	logic [63:0]        rhs;
	logic [31:0]        lat;
	logic [BIN_W-1:0]   walk_bin;
	logic [1:0]         cfg_idx_unused;
	bank_stat_t         qs;

	assign pready = 1'b1;
	assign in_stall = (state_q != ST_IDLE);
	assign accept = in_valid && !in_stall;
	assign rec_bank = pass_q ? BANK_GLOBAL : safe_bank(act_q);
	assign bin_start = accept && command == CMD_RECORD;
	assign cfg_idx_unused = paddr[1:0];

	always_comb begin
		prdata = '0;
		if (cfg_idx_unused == 2'd0) begin
			prdata = {18'd0, marks_q[paddr[4:2]]};
		end
	end

	lhpm_binner u_binner (
		.clk   (clk),
		.arst_n(arst_n),
		.start (bin_start),
		.value (sample_value),
		.done  (bin_done),
		.hit   (bin_hit),
		.bin   (bin_idx)
	);

	lhpm_ram #(.WIDTH(32), .DEPTH(MEM_DEPTH)) u_bins (
		.clk  (clk),
		.we   (we),
		.waddr(waddr),
		.wdata(wdata),
		.raddr(raddr),
		.rdata(rdata)
	);

	// walk: the RAM read is registered, so walk_bin (idx_q - 1) is the bin whose data is in rdata
	assign walk_bin = idx_q - 1'b1;
	assign qs = stat_q[qbank_q];
	assign lhs = total_q * 64'd10000;
	assign rhs = {50'd0, marks_q[mp_q]} * {32'd0, qs.count};
	assign take_mark = !marks_done_q && total_q < {32'd0, qs.count} && lhs >= rhs;

	// wscale_q and wrem_q track the scale and offset of walk_bin
	always_comb begin
		lat = 32'({25'd0, wrem_q} * POW_TEN[wscale_q]);
	end

	always_comb begin
		we = 1'b0;
		waddr = clr_q;
		wdata = '0;
		raddr = mem_addr(rec_bank, bin_q);
		case (state_q)
			ST_CLEAR: begin
				we = 1'b1;
			end
			ST_SNAP: begin
				we = 1'b1;
				waddr = mem_addr(act_q, idx_q);
			end
			ST_WR: begin
				we = 1'b1;
				waddr = mem_addr(rec_bank, bin_q);
				wdata = (rdata == 32'hFFFF_FFFF) ? rdata : rdata + 1'b1;
			end
			ST_WALK: begin
				raddr = mem_addr(qbank_q, idx_q);
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			clr_q <= '0;
			for (int i = 0; i < NUM_MARKS; i++) begin
				marks_q[i] <= MARK_RESET[i];
				vals_q[i] <= '0;
			end
			for (int k = 0; k < NUM_BANKS; k++) begin
				stat_q[k] <= STAT_CLEAR;
			end
			act_q <= BANK_ONE;
			snap_q <= BANK_TWO;
			out_valid <= 1'b0;
			pass_q <= 1'b0;
			rd_pend_q <= 1'b0;
			idx_q <= '0;
			bin_q <= '0;
			samp_q <= '0;
			qbank_q <= BANK_GLOBAL;
			mp_q <= '0;
			marks_done_q <= 1'b0;
			total_q <= '0;
			oi_q <= '0;
			wscale_q <= '0;
			wrem_q <= '0;
		end else begin
			if (psel && penable && pwrite && paddr[1:0] == 2'd0) begin
				marks_q[paddr[4:2]] <= pwdata[MARK_W-1:0];
			end
			case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == ADDR_W'(MEM_DEPTH - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (accept) begin
						samp_q <= sample_value;
						idx_q <= '0;
						case (command)
							CMD_RECORD: state_q <= ST_BIN;
							CMD_SNAPSHOT: begin
								act_q <= safe_bank(snap_q);
								snap_q <= safe_bank(act_q);
								stat_q[safe_bank(snap_q)] <= STAT_CLEAR;
								state_q <= ST_SNAP;
							end
							CMD_QUERY: begin
								qbank_q <= query_set ? BANK_GLOBAL : safe_bank(snap_q);
								mp_q <= '0;
								marks_done_q <= 1'b0;
								total_q <= '0;
								rd_pend_q <= 1'b0;
								wscale_q <= '0;
								wrem_q <= '0;
								state_q <= ST_WALK;
							end
							default: state_q <= ST_IDLE;
						endcase
					end
				end
				ST_BIN: begin
					if (bin_done) begin
						bin_q <= bin_idx;
						pass_q <= 1'b0;
						state_q <= bin_hit ? ST_RD : ST_IDLE;
					end
				end
				ST_RD: begin
					state_q <= ST_WR;
				end
				ST_WR: begin
					// update summary registers of this pass's bank
					if (stat_q[rec_bank].count != 32'hFFFF_FFFF) begin
						stat_q[rec_bank].count <= stat_q[rec_bank].count + 1'b1;
					end
					stat_q[rec_bank].sum <= stat_q[rec_bank].sum + {32'd0, samp_q};
					if (samp_q < stat_q[rec_bank].min) stat_q[rec_bank].min <= samp_q;
					if (samp_q > stat_q[rec_bank].max) stat_q[rec_bank].max <= samp_q;
					if (pass_q) begin
						pass_q <= 1'b0;
						state_q <= ST_IDLE;
					end else begin
						pass_q <= 1'b1;
						state_q <= ST_RD;
					end
				end
				ST_SNAP: begin
					idx_q <= idx_q + 1'b1;
					if (idx_q == BIN_W'(BANK_BINS - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_WALK: begin
					// idx_q addresses the next bin; rdata holds bin idx_q-1
					if (idx_q != BIN_W'(BANK_BINS)) begin
						idx_q <= idx_q + 1'b1;
					end
					rd_pend_q <= 1'b1;
					if (rd_pend_q) begin
						if (take_mark) begin
							vals_q[mp_q] <= lat;
							mp_q <= mp_q + 1'b1;
							if (mp_q == 3'(NUM_MARKS - 1)) marks_done_q <= 1'b1;
						end
						total_q <= total_q + {32'd0, rdata};
						if (wrem_q == 7'(BIN_SIZE - 1)) begin
							wrem_q <= '0;
							wscale_q <= wscale_q + 1'b1;
						end else begin
							wrem_q <= wrem_q + 1'b1;
						end
						if (walk_bin == BIN_W'(BANK_BINS - 1)) begin
							state_q <= ST_OUT;
							oi_q <= '0;
							out_valid <= 1'b1;
						end
					end
				end
				ST_OUT: begin
					if (!out_stall) begin
						oi_q <= oi_q + 1'b1;
						if (oi_q == 3'(NUM_MARKS - 1)) begin
							out_valid <= 1'b0;
							state_q <= ST_IDLE;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// marks never taken report the bank max
	always_comb begin
		mark_index = oi_q;
		percentile_value = (!marks_done_q && oi_q >= mp_q) ? qs.max : vals_q[oi_q];
		sample_count = qs.count;
		sample_sum = qs.sum;
		smallest_seen = qs.min;
		largest_seen = qs.max;
		last_of_run = (oi_q == 3'(NUM_MARKS - 1));
	end

`ifndef ASSERT_OFF
	a_out_only_in_out: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> state_q == ST_OUT)
		else $error("result word outside output phase");
	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_CLEAR |-> in_stall)
		else $error("item taken during memory clear");
	a_banks_differ: assert property (@(posedge clk) disable iff (!arst_n)
		act_q != snap_q)
		else $error("active and snapshot bank coincide");
	a_last_ends: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_stall && last_of_run |=> !out_valid)
		else $error("output continues after last word");
`endif
endmodule
